// ----- hw/rtl/ppmfd_pkg.sv -----
// Package for the PPM frame decoder: widths, reset values, result kinds,
// register indexes and the controller state type.
// Used by every module of the decoder; depends on nothing.
package ppmfd_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int TIME_W  = 16;
  localparam int SLOT_W  = 16;
  localparam int KIND_W  = 2;
  localparam int CHIDX_W = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Output tdata: channel_index then pulse_width, padded to whole bytes.
  localparam int OUT_DATA_W = ((CHIDX_W + SLOT_W + 7) / 8) * 8;

  localparam logic [TIME_W-1:0] SYNC_GAP_RESET  = 16'd2500;
  localparam logic [TIME_W-1:0] MIN_PULSE_RESET = 16'd800;
  localparam logic [TIME_W-1:0] MAX_PULSE_RESET = 16'd2200;
  localparam logic [SLOT_W-1:0] SLOT_RESET      = 16'd1500;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd3;

  localparam logic [1:0] REG_SYNC_GAP  = 2'd0;
  localparam logic [1:0] REG_MIN_PULSE = 2'd1;
  localparam logic [1:0] REG_MAX_PULSE = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] sync_gap_us;
    logic [TIME_W-1:0] min_pulse_us;
    logic [TIME_W-1:0] max_pulse_us;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_FRAME
  } state_t;

endpackage

// ----- hw/rtl/ppmfd_cell.sv -----
// One channel slot of the decoder's slot chain.
// Loads a new pulse width or takes its neighbor's value; uses ppmfd_pkg.
module ppmfd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic                           rot_en,
  input  logic [ppmfd_pkg::SLOT_W-1:0]   wr_data,
  input  logic [ppmfd_pkg::SLOT_W-1:0]   nbr_data,
  output logic [ppmfd_pkg::SLOT_W-1:0]   slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= ppmfd_pkg::SLOT_RESET;
    end else if (rot_en) begin
      slot <= nbr_data;
    end else if (wr_en) begin
      slot <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/ppmfd_cfg.sv -----
// Configuration registers of the decoder behind an APB-style port.
// Holds sync gap and pulse limits; uses ppmfd_pkg.
module ppmfd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppmfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppmfd_pkg::DATA_W-1:0]  pwdata,
  output logic [ppmfd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output ppmfd_pkg::cfg_t               cfg
);

  logic       wr_req;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_req  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_gap_us  <= ppmfd_pkg::SYNC_GAP_RESET;
      cfg.min_pulse_us <= ppmfd_pkg::MIN_PULSE_RESET;
      cfg.max_pulse_us <= ppmfd_pkg::MAX_PULSE_RESET;
    end else if (wr_req) begin
      case (reg_idx)
        ppmfd_pkg::REG_SYNC_GAP:  cfg.sync_gap_us  <= pwdata[ppmfd_pkg::TIME_W-1:0];
        ppmfd_pkg::REG_MIN_PULSE: cfg.min_pulse_us <= pwdata[ppmfd_pkg::TIME_W-1:0];
        ppmfd_pkg::REG_MAX_PULSE: cfg.max_pulse_us <= pwdata[ppmfd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ppmfd_pkg::REG_SYNC_GAP:  prdata = ppmfd_pkg::DATA_W'(cfg.sync_gap_us);
      ppmfd_pkg::REG_MIN_PULSE: prdata = ppmfd_pkg::DATA_W'(cfg.min_pulse_us);
      ppmfd_pkg::REG_MAX_PULSE: prdata = ppmfd_pkg::DATA_W'(cfg.max_pulse_us);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/ppm_frame_decoder.sv -----
// PPM frame decoder top level: edge stream in, classified results out.
// Instantiates ppmfd_cfg and a chain of ppmfd_cell; uses ppmfd_pkg.
//
// Each input request is the 16-bit microsecond timestamp of one signal edge.
// The edge is taken in the idle state, the gap to the previous edge is
// registered in that same cycle, and the gap is classified in the next one;
// a result that must wait for the output register holds the decoder there.
// A sync gap that closes a complete frame then reads the channel slots out of
// the cell chain by rotating it one position per cycle while the output side
// takes results; after a full turn each cell holds its own value again.
// Results go through an output register, so a new edge is taken while the
// last result still waits on the output.
module ppm_frame_decoder #(
  parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Edge input.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ppmfd_pkg::TIME_W-1:0]      s_tdata,   // [15:0] edge_time
  // Result output.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ppmfd_pkg::OUT_DATA_W-1:0]  m_tdata,   // [3:0] channel_index,
                                                       // [19:4] pulse_width, rest 0
  output logic [ppmfd_pkg::KIND_W-1:0]      m_tuser,   // [1:0] kind
  output logic                              m_tlast,
  // Configuration.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppmfd_pkg::ADDR_W-1:0]      paddr,
  input  logic [ppmfd_pkg::DATA_W-1:0]      pwdata,
  output logic [ppmfd_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CHANNELS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHANNELS - 1);

  ppmfd_pkg::cfg_t   cfg;
  ppmfd_pkg::state_t state, state_next;

  logic [ppmfd_pkg::TIME_W-1:0]  prev_edge;
  logic [ppmfd_pkg::TIME_W-1:0]  gap;
  logic [CNT_W-1:0]              slots_filled;
  logic [CNT_W-1:0]              emit_cnt;

  logic [ppmfd_pkg::KIND_W-1:0]  out_kind, out_kind_next;
  logic [ppmfd_pkg::CHIDX_W-1:0] out_idx, out_idx_next;
  logic [ppmfd_pkg::SLOT_W-1:0]  out_width, out_width_next;
  logic                          out_last, out_last_next;
  logic                          out_load;

  logic out_free, in_take, is_sync, frame_full, in_range, emit_last;
  logic cell_wr, cell_rot, fill_clr, fill_inc;

  logic [ppmfd_pkg::SLOT_W-1:0] slot_val [CHANNELS];

  ppmfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Cell i reads from cell i+1 (the last cell from cell 0) while rotating; the head cell feeds the output.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    ppmfd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (cell_wr && (slots_filled == CNT_W'(i))),
      .rot_en   (cell_rot),
      .wr_data  (gap),
      .nbr_data (slot_val[(i + 1) % CHANNELS]),
      .slot     (slot_val[i])
    );
  end

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ppmfd_pkg::ST_IDLE);
  assign in_take    = s_tvalid && s_tready;
  assign is_sync    = gap > cfg.sync_gap_us;
  assign frame_full = slots_filled >= FULL_CNT;
  assign in_range   = !(gap > cfg.max_pulse_us || gap < cfg.min_pulse_us);
  assign emit_last  = (emit_cnt == LAST_CNT);

  always_comb begin
    state_next = state;
    unique case (state)
      ppmfd_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = ppmfd_pkg::ST_CLASS;
        end
      end
      ppmfd_pkg::ST_CLASS: begin
        if (is_sync && frame_full) begin
          state_next = ppmfd_pkg::ST_FRAME;
        end else if (out_free) begin
          state_next = ppmfd_pkg::ST_IDLE;
        end
      end
      ppmfd_pkg::ST_FRAME: begin
        if (out_free && emit_last) begin
          state_next = ppmfd_pkg::ST_IDLE;
        end
      end
      default: state_next = ppmfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_load       = 1'b0;
    out_kind_next  = ppmfd_pkg::KIND_ACCEPT;
    out_idx_next   = '0;
    out_width_next = gap;
    out_last_next  = 1'b1;
    cell_wr        = 1'b0;
    cell_rot       = 1'b0;
    fill_clr       = 1'b0;
    fill_inc       = 1'b0;
    unique case (state)
      ppmfd_pkg::ST_CLASS: begin
        if (is_sync && frame_full) begin
          fill_clr = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          if (is_sync) begin
            out_kind_next = ppmfd_pkg::KIND_SYNC;
            fill_clr      = 1'b1;
          end else if (!in_range) begin
            out_kind_next = ppmfd_pkg::KIND_REJECT;
          end else begin
            out_kind_next = ppmfd_pkg::KIND_ACCEPT;
            cell_wr       = !frame_full;
            fill_inc      = !frame_full;
          end
        end
      end
      ppmfd_pkg::ST_FRAME: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_next  = ppmfd_pkg::KIND_FRAME;
          out_idx_next   = ppmfd_pkg::CHIDX_W'(emit_cnt);
          out_width_next = slot_val[0];
          out_last_next  = emit_last;
          cell_rot       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ppmfd_pkg::ST_IDLE;
      prev_edge    <= '0;
      slots_filled <= '0;
      emit_cnt     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        prev_edge <= s_tdata;
      end
      if (fill_clr) begin
        slots_filled <= '0;
      end else if (fill_inc) begin
        slots_filled <= slots_filled + 1'b1;
      end
      if (cell_rot) begin
        emit_cnt <= emit_last ? '0 : emit_cnt + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      gap <= s_tdata - prev_edge;
    end
    if (out_load) begin
      out_kind  <= out_kind_next;
      out_idx   <= out_idx_next;
      out_width <= out_width_next;
      out_last  <= out_last_next;
    end
  end

  assign m_tuser = out_kind;
  assign m_tlast = out_last;
  assign m_tdata = ppmfd_pkg::OUT_DATA_W'({out_width, out_idx});

endmodule

// ----- tb/sv/ppmfd_checker.sv -----
// Result checker for the PPM frame decoder testbench: follows the register
// port, the edge requests and the result stream, and predicts every result.
// Depends on ppmfd_pkg for widths, reset values, result kinds and register indexes.
`timescale 1ns / 100ps

module ppmfd_checker #(
  parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [ppmfd_pkg::TIME_W-1:0]     s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ppmfd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [ppmfd_pkg::KIND_W-1:0]     m_tuser,
  input  logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [ppmfd_pkg::ADDR_W-1:0]     paddr,
  input  logic [ppmfd_pkg::DATA_W-1:0]     pwdata,
  input  logic [ppmfd_pkg::DATA_W-1:0]     prdata,
  output int                               fail_count,
  output int                               pending,
  output int                               result_count,
  output int                               frame_count
);

  typedef struct packed {
    logic [ppmfd_pkg::KIND_W-1:0]  kind;
    logic [ppmfd_pkg::CHIDX_W-1:0] chan;
    logic [ppmfd_pkg::SLOT_W-1:0]  width;
    logic                          last;
  } ppm_result_t;

  ppmfd_pkg::cfg_t              cfg;
  logic [ppmfd_pkg::TIME_W-1:0] last_edge;
  logic [4:0]                   filled;
  logic [ppmfd_pkg::SLOT_W-1:0] slot_val [CHANNELS];
  logic [1:0]                   reg_idx;
  ppm_result_t                  due_results [$];
  ppm_result_t                  got;
  ppm_result_t                  want;
  int                           fails;
  int                           results;
  int                           frames;

  assign reg_idx = paddr[ppmfd_pkg::ADDR_W-1:2];

  task automatic push_result(input logic [ppmfd_pkg::KIND_W-1:0] kind, input int chan,
                             input logic [ppmfd_pkg::SLOT_W-1:0] width, input logic last);
    ppm_result_t r;
    r.kind  = kind;
    r.chan  = ppmfd_pkg::CHIDX_W'(chan);
    r.width = width;
    r.last  = last;
    due_results.push_back(r);
  endtask

  task automatic decode_edge(input logic [ppmfd_pkg::TIME_W-1:0] edge_time);
    logic [ppmfd_pkg::TIME_W-1:0] gap;
    int i;
    gap = edge_time - last_edge;
    last_edge = edge_time;
    if (gap > cfg.sync_gap_us) begin
      if (filled >= CHANNELS) begin
        for (i = 0; i < CHANNELS; i++)
          push_result(ppmfd_pkg::KIND_FRAME, i, slot_val[i], i == CHANNELS - 1);
        frames++;
      end else begin
        push_result(ppmfd_pkg::KIND_SYNC, 0, gap, 1'b1);
      end
      filled = '0;
    end else if (gap > cfg.max_pulse_us || gap < cfg.min_pulse_us) begin
      push_result(ppmfd_pkg::KIND_REJECT, 0, gap, 1'b1);
    end else begin
      // Once every slot holds a value, further pulses are reported but not stored.
      if (filled < CHANNELS) begin
        slot_val[filled] = gap;
        filled = filled + 5'd1;
      end
      push_result(ppmfd_pkg::KIND_ACCEPT, 0, gap, 1'b1);
    end
  endtask

  function automatic logic [ppmfd_pkg::TIME_W-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      ppmfd_pkg::REG_SYNC_GAP:  return cfg.sync_gap_us;
      ppmfd_pkg::REG_MIN_PULSE: return cfg.min_pulse_us;
      default:                  return cfg.max_pulse_us;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.sync_gap_us  = ppmfd_pkg::SYNC_GAP_RESET;
      cfg.min_pulse_us = ppmfd_pkg::MIN_PULSE_RESET;
      cfg.max_pulse_us = ppmfd_pkg::MAX_PULSE_RESET;
      last_edge = '0;
      filled = '0;
      for (int i = 0; i < CHANNELS; i++)
        slot_val[i] = ppmfd_pkg::SLOT_RESET;
      due_results.delete();
      fails = 0;
      results = 0;
      frames = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx)
          ppmfd_pkg::REG_SYNC_GAP:  cfg.sync_gap_us  = pwdata[ppmfd_pkg::TIME_W-1:0];
          ppmfd_pkg::REG_MIN_PULSE: cfg.min_pulse_us = pwdata[ppmfd_pkg::TIME_W-1:0];
          ppmfd_pkg::REG_MAX_PULSE: cfg.max_pulse_us = pwdata[ppmfd_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (psel && penable && !pwrite && pready &&
          (reg_idx == ppmfd_pkg::REG_SYNC_GAP || reg_idx == ppmfd_pkg::REG_MIN_PULSE ||
           reg_idx == ppmfd_pkg::REG_MAX_PULSE) &&
          prdata[ppmfd_pkg::TIME_W-1:0] !== reg_value(reg_idx)) begin
        $error("register read at %0d: expected %0d, got %0d", paddr,
               reg_value(reg_idx), prdata[ppmfd_pkg::TIME_W-1:0]);
        fails++;
      end

      if (m_tvalid && m_tready) begin
        got.kind  = m_tuser;
        got.chan  = m_tdata[ppmfd_pkg::CHIDX_W-1:0];
        got.width = m_tdata[ppmfd_pkg::CHIDX_W +: ppmfd_pkg::SLOT_W];
        got.last  = m_tlast;
        results++;
        if (due_results.size() == 0) begin
          $error("result with none due: kind %0d channel_index %0d pulse_width %0d last %0d",
                 got.kind, got.chan, got.width, got.last);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fails++;
          end
          if (got.chan !== want.chan) begin
            $error("channel_index: expected %0d, got %0d", want.chan, got.chan);
            fails++;
          end
          if (got.width !== want.width) begin
            $error("pulse_width: expected %0d, got %0d", want.width, got.width);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fails++;
          end
        end
      end

      // Results never leave in the cycle their edge request is taken, so the
      // prediction for a new edge goes in after the output comparison.
      if (s_tvalid && s_tready)
        decode_edge(s_tdata);
    end
    fail_count   <= fails;
    pending      <= due_results.size();
    result_count <= results;
    frame_count  <= frames;
  end

endmodule

// ----- tb/sv/tb_ppm_frame_decoder.sv -----
// Top of the PPM frame decoder testbench: clock, reset, register setup, edge
// stimulus and output back-pressure, with the verdict at the end.
// Depends on ppmfd_pkg, ppm_frame_decoder and ppmfd_checker.
`timescale 1ns / 100ps

module tb_ppm_frame_decoder;

  localparam int          CHANNELS   = ppmfd_pkg::CHANNELS_DEF;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          HOLD_LEN   = 400;
  localparam logic [1:0]  REG_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [ppmfd_pkg::TIME_W-1:0]     s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [ppmfd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [ppmfd_pkg::KIND_W-1:0]     m_tuser;
  logic                             m_tlast;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [ppmfd_pkg::ADDR_W-1:0]     paddr = '0;
  logic [ppmfd_pkg::DATA_W-1:0]     pwdata = '0;
  logic [ppmfd_pkg::DATA_W-1:0]     prdata;
  logic                             pready;

  int fail_count;
  int pending;
  int result_count;
  int frame_count;

  // Stimulus bookkeeping: the last edge time sent and the register values written.
  logic [ppmfd_pkg::TIME_W-1:0] stamp = '0;
  int  cur_sync = 2500;
  int  cur_min  = 800;
  int  cur_max  = 2200;
  int  edges_sent = 0;
  int  settings_used = 1;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_served = 1'b0;
  int  hold_left = 0;
  int  cycle_cnt = 0;

  int dir_gaps [17] = '{3000, 800, 2200, 1000, 1200, 1400, 1600, 1800, 2000,
                        1500, 799, 2201, 0, 2500, 2501, 65535, 1500};

  int extreme_cfg [5][3] = '{'{0, 0, 65535}, '{65535, 0, 65535}, '{2500, 2000, 1000},
                             '{2000, 1500, 1500}, '{65535, 65535, 65535}};

  ppm_frame_decoder #(.CHANNELS(CHANNELS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ppmfd_checker #(.CHANNELS(CHANNELS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .frame_count(frame_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("ppm_frame_decoder: mismatch");
      $finish;
    end
  end

  // Output back-pressure, including one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_served <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  task automatic offer_edge(input logic [ppmfd_pkg::TIME_W-1:0] t);
    while (!calm && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= t;
    stamp = t;
    edges_sent++;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  task automatic step_gap(input int gap);
    offer_edge(stamp + ppmfd_pkg::TIME_W'(gap));
  endtask

  // Wait until every predicted result has left the decoder.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    logic [15:0] junk;
    junk = 16'($urandom);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk, 16'(value)};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      ppmfd_pkg::REG_SYNC_GAP:  cur_sync = value;
      ppmfd_pkg::REG_MIN_PULSE: cur_min = value;
      ppmfd_pkg::REG_MAX_PULSE: cur_max = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int sync_gap, input int min_pulse, input int max_pulse);
    settle();
    write_reg(ppmfd_pkg::REG_SYNC_GAP, sync_gap);
    write_reg(ppmfd_pkg::REG_MIN_PULSE, min_pulse);
    write_reg(ppmfd_pkg::REG_MAX_PULSE, max_pulse);
    // A write beyond the last register must leave all three untouched.
    write_reg(REG_UNUSED, $urandom_range(65535));
    read_reg(ppmfd_pkg::REG_SYNC_GAP);
    read_reg(ppmfd_pkg::REG_MIN_PULSE);
    read_reg(ppmfd_pkg::REG_MAX_PULSE);
    settings_used++;
  endtask

  function automatic int gap_sync();
    if (cur_sync >= 65535)
      return $urandom_range(65535);
    return $urandom_range(65535, cur_sync + 1);
  endfunction

  function automatic int gap_pulse();
    int hi;
    hi = (cur_max < cur_sync) ? cur_max : cur_sync;
    if (cur_min > hi)
      return $urandom_range(cur_sync);
    return $urandom_range(hi, cur_min);
  endfunction

  function automatic int gap_reject();
    int hi;
    hi = (cur_min - 1 < cur_sync) ? cur_min - 1 : cur_sync;
    if (cur_min > 0 && ($urandom_range(1) == 0 || cur_max >= cur_sync))
      return $urandom_range(hi);
    if (cur_max < cur_sync)
      return $urandom_range(cur_sync, cur_max + 1);
    return $urandom_range(cur_sync);
  endfunction

  // Mostly complete frames with random widths; the rest are short frames,
  // overfull frames and raw edges at random times.
  task automatic run_frames(input int count);
    int target;
    int pick;
    int n;
    int i;
    target = edges_sent + count;
    while (edges_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        step_gap(gap_sync());
        if (pick < 70)
          n = CHANNELS;
        else if (pick < 80)
          n = $urandom_range(CHANNELS - 1);
        else
          n = CHANNELS + $urandom_range(3, 1);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0)
            step_gap(gap_reject());
          step_gap(gap_pulse());
        end
      end else begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++)
          offer_edge(ppmfd_pkg::TIME_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed edges at the reset register values.
    foreach (dir_gaps[k])
      step_gap(dir_gaps[k]);
    offer_edge(16'hFFFF);
    offer_edge(16'h0000);
    offer_edge(16'hFC00);
    step_gap(1200);

    apply_setting(3000, 1000, 2000);
    calm <= 1'b1;
    run_frames(50);
    calm <= 1'b0;
    run_frames(30);
    // The sender keeps offering edges while the output side holds off.
    hold_req <= 1'b1;
    run_frames(30);
    settle();
    run_frames(50);

    for (int k = 0; k < 5; k++) begin
      apply_setting(extreme_cfg[k][0], extreme_cfg[k][1], extreme_cfg[k][2]);
      run_frames(15);
    end
    for (int k = 0; k < 2; k++) begin
      apply_setting($urandom_range(4000, 1500), $urandom_range(1200, 500),
                    $urandom_range(2500, 1500));
      run_frames(20);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d edges under %0d register settings.", edges_sent, settings_used);
    $display("Checked %0d results, %0d of them from %0d complete frames.",
             result_count, frame_count * CHANNELS, frame_count);
    if (fail_count == 0)
      $display("ppm_frame_decoder: match");
    else
      $display("ppm_frame_decoder: mismatch");
    $finish;
  end

endmodule
